// ===== design/ising_metropolis_site_update_unit_macros.svh =====
// Assertion macros shared by the checker of the Ising site update unit.
`ifndef ISING_METROPOLIS_SITE_UPDATE_UNIT_MACROS_SVH
`define ISING_METROPOLIS_SITE_UPDATE_UNIT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ISMU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ISMU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ismu_pkg.sv =====
// Shared types and constants of the Ising Metropolis site update unit.
`timescale 1ns / 1ps
`default_nettype none

package ismu_pkg;

    localparam int MAX_POINTS_DEF  = 256;
    localparam int RANDOM_BITS_DEF = 16;

    localparam int POINT_W   = 8;
    localparam int RAND_W    = 16;
    localparam int THR_W     = 16;
    localparam int MAG_W     = 11;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [THR_W-1:0] THR_ONE_RST   = 16'd24109;
    localparam logic [THR_W-1:0] THR_THREE_RST = 16'd3263;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_UPDATE = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THR_ONE   = 1'b0,
        CFG_THR_THREE = 1'b1
    } cfg_idx_t;

    // Per-site state word: loaded flag and spin bit (1 means +1).
    typedef struct packed {
        logic loaded;
        logic spin;
    } site_word_t;

    // Three neighbour indices of one site, all on the other side.
    typedef struct packed {
        logic [POINT_W-1:0] n0;
        logic [POINT_W-1:0] n1;
        logic [POINT_W-1:0] n2;
    } nbr_word_t;

endpackage

`default_nettype wire

// ===== design/ismu_state_mem.sv =====
// Site state memory: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module ismu_state_mem #(
    parameter int DEPTH  = 2 * ismu_pkg::MAX_POINTS_DEF,
    parameter int ADDR_W = $clog2(2 * ismu_pkg::MAX_POINTS_DEF)
) (
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_W-1:0]    wr_addr,
    input  wire ismu_pkg::site_word_t wr_data,
    input  wire logic [ADDR_W-1:0]    rd_addr_a,
    input  wire logic [ADDR_W-1:0]    rd_addr_b,
    output ismu_pkg::site_word_t      rd_data_a,
    output ismu_pkg::site_word_t      rd_data_b
);
    import ismu_pkg::*;

    site_word_t mem [DEPTH];
    site_word_t rd_a_reg;
    site_word_t rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

// ===== design/ismu_nbr_mem.sv =====
// Neighbour index memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ismu_nbr_mem #(
    parameter int DEPTH  = 2 * ismu_pkg::MAX_POINTS_DEF,
    parameter int ADDR_W = $clog2(2 * ismu_pkg::MAX_POINTS_DEF)
) (
    input  wire logic                aclk,
    input  wire logic                wr_en,
    input  wire logic [ADDR_W-1:0]   wr_addr,
    input  wire ismu_pkg::nbr_word_t wr_data,
    input  wire logic [ADDR_W-1:0]   rd_addr,
    output ismu_pkg::nbr_word_t      rd_data
);
    import ismu_pkg::*;

    nbr_word_t mem [DEPTH];
    nbr_word_t rd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_data = rd_reg;

endmodule

`default_nettype wire

// ===== design/ising_metropolis_site_update_unit.sv =====
// Top level of the Ising Metropolis site update unit: sequencer, datapath, memories.
`timescale 1ns / 1ps
`default_nettype none

// Metropolis spin update engine for an Ising model on a bipartite graph where
// every site has three neighbours on the other side. Site state (loaded flag
// and spin) sits in a memory with two read ports; neighbour indices sit in a
// second memory. A load beat writes a site's neighbours and spin, an update
// beat counts matching neighbours and flips on a negative energy change or
// when the random value is at or below the threshold register for that
// change, a read beat returns the spin. Every input beat gives one result
// beat carrying the running magnetization sum. After reset the unit clears
// the site state memory, one entry a cycle, with s_ready low until every
// entry is clear; configuration writes are taken at any time. Items are
// handled one at a time: load, read, no-op and updates of never loaded sites
// pass through S_SITE and S_DONE before the next accept, an update of a
// loaded site through S_SITE, S_NB1, S_NB2 and S_DONE, as the reads of the
// site state memory are registered (own site first, then the three neighbour
// spins through its two read ports). A finished result waits in the output
// register; a new item can be accepted meanwhile, and its commit waits only
// if the previous result is still not taken.
module ising_metropolis_site_update_unit #(
    parameter int MAX_POINTS  = ismu_pkg::MAX_POINTS_DEF,
    parameter int RANDOM_BITS = ismu_pkg::RANDOM_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ismu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ismu_pkg::THR_W-1:0]        cfg_data,
    // input item channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [ismu_pkg::OP_W-1:0]         s_op,
    input  wire logic                              s_side,
    input  wire logic [ismu_pkg::POINT_W-1:0]      s_point,
    input  wire logic [ismu_pkg::POINT_W-1:0]      s_neighbour_first,
    input  wire logic [ismu_pkg::POINT_W-1:0]      s_neighbour_second,
    input  wire logic [ismu_pkg::POINT_W-1:0]      s_neighbour_third,
    input  wire logic                              s_spin_in,
    input  wire logic [ismu_pkg::RAND_W-1:0]       s_random_value,
    // result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_spin_out,
    output logic                                   m_flipped,
    output logic signed [ismu_pkg::MAG_W-1:0]      m_magnet_sum,
    output logic                                   m_not_loaded
);
    import ismu_pkg::*;

    localparam int SITES  = 2 * MAX_POINTS;
    localparam int ADDR_W = $clog2(SITES);

    localparam logic [15:0]       PT_LIMIT  = 16'(MAX_POINTS);
    localparam logic [ADDR_W-1:0] SIDE_BASE = ADDR_W'(MAX_POINTS);
    localparam logic [ADDR_W-1:0] LAST_SITE = ADDR_W'(SITES - 1);
    // only the low RANDOM_BITS bits of the random value take part
    localparam logic [RAND_W-1:0] RAND_MASK = RAND_W'((64'd1 << RANDOM_BITS) - 64'd1);

    localparam logic signed [MAG_W-1:0] SPIN_POS = 11'sd1;
    localparam logic signed [MAG_W-1:0] SPIN_NEG = -11'sd1;
    localparam logic signed [MAG_W-1:0] FLIP_UP  = 11'sd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SITE,
        S_NB1,
        S_NB2,
        S_DONE
    } state_t;

    // Site index within its side to flat memory address (side 1 sits above side 0).
    function automatic logic [ADDR_W-1:0] site_addr(input logic sd,
                                                    input logic [POINT_W-1:0] pt);
        logic [15:0] ext;
        ext = {8'b0, pt};
        return ADDR_W'(ext) + (sd ? SIDE_BASE : '0);
    endfunction

    function automatic logic in_range(input logic [POINT_W-1:0] pt);
        return {8'b0, pt} < PT_LIMIT;
    endfunction

    function automatic logic signed [MAG_W-1:0] spin_val(input logic sp);
        return sp ? SPIN_POS : SPIN_NEG;
    endfunction

    state_t                    state_reg;
    logic [ADDR_W-1:0]         clr_addr_reg;

    // latched item
    op_t                       op_reg;
    logic                      side_reg;
    logic                      point_ok_reg;
    logic [ADDR_W-1:0]         site_reg;
    logic                      spin_in_reg;
    logic [RAND_W-1:0]         rnd_reg;
    nbr_word_t                 nbr_in_reg;

    // update work registers
    site_word_t                own_reg;
    logic [2:0]                nb_ok_reg;
    logic [1:0]                match_reg;

    // pending commit
    logic                      res_spin_reg;
    logic                      res_flip_reg;
    logic                      res_nl_reg;
    logic                      wr_state_reg;
    logic                      wr_nbr_reg;
    site_word_t                wr_word_reg;
    logic signed [MAG_W-1:0]   mag_new_reg;
    logic signed [MAG_W-1:0]   mag_reg;

    // configuration
    logic [THR_W-1:0]          thr_one_reg;
    logic [THR_W-1:0]          thr_three_reg;

    // output register
    logic                      m_valid_reg;
    logic                      m_spin_reg;
    logic                      m_flip_reg;
    logic signed [MAG_W-1:0]   m_mag_reg;
    logic                      m_nl_reg;

    // memory ports
    logic                      st_wr_en;
    logic [ADDR_W-1:0]         st_wr_addr;
    site_word_t                st_wr_data;
    logic [ADDR_W-1:0]         st_rd_addr_a;
    logic [ADDR_W-1:0]         st_rd_addr_b;
    site_word_t                st_rd_a;
    site_word_t                st_rd_b;
    logic                      nb_wr_en;
    logic [ADDR_W-1:0]         nb_rd_addr;
    nbr_word_t                 nb_rd;

    // datapath
    logic                      out_free;
    logic                      commit;
    logic                      eff_a;
    logic                      eff_b;
    logic [1:0]                match_total;
    logic                      accept_flip;
    logic signed [MAG_W-1:0]   mag_load;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign out_free  = !m_valid_reg || m_ready;
    assign commit    = (state_reg == S_DONE) && out_free;

    // Read addresses: own site while idle (captured at accept), then the
    // neighbours on the other side: first and second together, third after.
    always_comb begin
        st_rd_addr_b = site_addr(!side_reg, nb_rd.n1);
        if (state_reg == S_IDLE) begin
            st_rd_addr_a = site_addr(s_side, s_point);
        end else if (state_reg == S_SITE) begin
            st_rd_addr_a = site_addr(!side_reg, nb_rd.n0);
        end else begin
            st_rd_addr_a = site_addr(!side_reg, nb_rd.n2);
        end
        nb_rd_addr = (state_reg == S_IDLE) ? site_addr(s_side, s_point) : site_reg;
    end

    // Write port: clearing pass after reset, else the commit of one item.
    always_comb begin
        if (state_reg == S_CLEAR) begin
            st_wr_en   = 1'b1;
            st_wr_addr = clr_addr_reg;
            st_wr_data = '0;
        end else begin
            st_wr_en   = commit && wr_state_reg;
            st_wr_addr = site_reg;
            st_wr_data = wr_word_reg;
        end
        nb_wr_en = commit && wr_nbr_reg;
    end

    // Neighbour spins: an index off the end of its side reads as spin -1.
    always_comb begin
        eff_a       = nb_ok_reg[0] && st_rd_a.spin;
        eff_b       = nb_ok_reg[1] && st_rd_b.spin;
        match_total = match_reg + {1'b0, (nb_ok_reg[2] && st_rd_a.spin) == own_reg.spin};
        // fewer than two matches is a negative energy change: always flip
        unique case (match_total)
            2'd0, 2'd1: accept_flip = 1'b1;
            2'd2:       accept_flip = (rnd_reg <= thr_one_reg);
            default:    accept_flip = (rnd_reg <= thr_three_reg);
        endcase
        // a reload takes the old spin out of the sum first
        mag_load = mag_reg - (st_rd_a.loaded ? spin_val(st_rd_a.spin) : '0)
                 + spin_val(spin_in_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_one_reg   <= THR_ONE_RST;
            thr_three_reg <= THR_THREE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_THR_ONE:   thr_one_reg   <= cfg_data;
                CFG_THR_THREE: thr_three_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            mag_reg      <= '0;
            m_valid_reg  <= 1'b0;
            wr_state_reg <= 1'b0;
            wr_nbr_reg   <= 1'b0;
        end else begin
            // drop the result once taken; a commit reloads it
            m_valid_reg <= commit || (m_valid_reg && !m_ready);
            unique case (state_reg)
                S_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (clr_addr_reg == LAST_SITE) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg       <= op_t'(s_op);
                        side_reg     <= s_side;
                        point_ok_reg <= in_range(s_point);
                        site_reg     <= site_addr(s_side, s_point);
                        spin_in_reg  <= s_spin_in;
                        rnd_reg      <= s_random_value & RAND_MASK;
                        nbr_in_reg   <= '{n0: s_neighbour_first,
                                          n1: s_neighbour_second,
                                          n2: s_neighbour_third};
                        state_reg    <= S_SITE;
                    end
                end
                S_SITE: begin
                    unique case (op_reg)
                        OP_LOAD: begin
                            // a load off the end of its side changes nothing
                            res_spin_reg <= point_ok_reg && spin_in_reg;
                            res_flip_reg <= 1'b0;
                            res_nl_reg   <= 1'b0;
                            wr_state_reg <= point_ok_reg;
                            wr_nbr_reg   <= point_ok_reg;
                            wr_word_reg  <= '{loaded: 1'b1, spin: spin_in_reg};
                            mag_new_reg  <= point_ok_reg ? mag_load : mag_reg;
                            state_reg    <= S_DONE;
                        end
                        OP_UPDATE, OP_READ: begin
                            res_flip_reg <= 1'b0;
                            wr_nbr_reg   <= 1'b0;
                            if (!point_ok_reg || !st_rd_a.loaded) begin
                                res_nl_reg   <= 1'b1;
                                res_spin_reg <= point_ok_reg && st_rd_a.spin;
                                wr_state_reg <= 1'b0;
                                mag_new_reg  <= mag_reg;
                                state_reg    <= S_DONE;
                            end else if (op_reg == OP_READ) begin
                                res_nl_reg   <= 1'b0;
                                res_spin_reg <= st_rd_a.spin;
                                wr_state_reg <= 1'b0;
                                mag_new_reg  <= mag_reg;
                                state_reg    <= S_DONE;
                            end else begin
                                res_nl_reg <= 1'b0;
                                own_reg    <= st_rd_a;
                                nb_ok_reg  <= {in_range(nb_rd.n2), in_range(nb_rd.n1),
                                               in_range(nb_rd.n0)};
                                state_reg  <= S_NB1;
                            end
                        end
                        OP_NOP: begin
                            res_spin_reg <= 1'b0;
                            res_flip_reg <= 1'b0;
                            res_nl_reg   <= 1'b0;
                            wr_state_reg <= 1'b0;
                            wr_nbr_reg   <= 1'b0;
                            mag_new_reg  <= mag_reg;
                            state_reg    <= S_DONE;
                        end
                    endcase
                end
                S_NB1: begin
                    match_reg <= {1'b0, eff_a == own_reg.spin}
                               + {1'b0, eff_b == own_reg.spin};
                    state_reg <= S_NB2;
                end
                S_NB2: begin
                    res_spin_reg <= own_reg.spin ^ accept_flip;
                    res_flip_reg <= accept_flip;
                    wr_state_reg <= accept_flip;
                    wr_word_reg  <= '{loaded: 1'b1, spin: !own_reg.spin};
                    mag_new_reg  <= !accept_flip ? mag_reg
                                  : (own_reg.spin ? mag_reg - FLIP_UP : mag_reg + FLIP_UP);
                    state_reg    <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register is free, then commit
                    if (out_free) begin
                        m_spin_reg  <= res_spin_reg;
                        m_flip_reg  <= res_flip_reg;
                        m_nl_reg    <= res_nl_reg;
                        m_mag_reg   <= mag_new_reg;
                        mag_reg     <= mag_new_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_spin_out   = m_spin_reg;
    assign m_flipped    = m_flip_reg;
    assign m_magnet_sum = m_mag_reg;
    assign m_not_loaded = m_nl_reg;

    ismu_state_mem #(
        .DEPTH  (SITES),
        .ADDR_W (ADDR_W)
    ) u_state_mem (
        .aclk      (aclk),
        .wr_en     (st_wr_en),
        .wr_addr   (st_wr_addr),
        .wr_data   (st_wr_data),
        .rd_addr_a (st_rd_addr_a),
        .rd_addr_b (st_rd_addr_b),
        .rd_data_a (st_rd_a),
        .rd_data_b (st_rd_b)
    );

    ismu_nbr_mem #(
        .DEPTH  (SITES),
        .ADDR_W (ADDR_W)
    ) u_nbr_mem (
        .aclk    (aclk),
        .wr_en   (nb_wr_en),
        .wr_addr (site_reg),
        .wr_data (nbr_in_reg),
        .rd_addr (nb_rd_addr),
        .rd_data (nb_rd)
    );

endmodule

`default_nettype wire

// ===== design/ismu_checker.sv =====
// Port-level checker of the Ising site update unit and its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "ising_metropolis_site_update_unit_macros.svh"

module ismu_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_valid,
    input wire logic                              s_ready,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic                              m_flipped,
    input wire logic                              m_not_loaded,
    input wire logic signed [ismu_pkg::MAG_W-1:0] m_magnet_sum
);
    import ismu_pkg::*;

    logic [MAG_W-1:0] last_sum_reg;
    logic [MAG_W-1:0] sum_step;
    logic             out_beat;
    logic             step_small;
    logic             step_flip;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_sum_reg <= '0;
        end else if (out_beat) begin
            last_sum_reg <= m_magnet_sum;
        end
    end

    assign out_beat   = m_valid && m_ready;
    assign sum_step   = m_magnet_sum - last_sum_reg;
    assign step_flip  = (sum_step == 11'd2) || (sum_step == 11'h7FE);
    assign step_small = (sum_step == 11'd0) || (sum_step == 11'd1) ||
                        (sum_step == 11'h7FF) || step_flip;

    // one item moves the sum by at most two
    `ISMU_ASSERT_NOW(a_sum_step, aclk, aresetn, out_beat, step_small, "sum jumped by more than two")
    // a flip moves the sum by exactly two
    `ISMU_ASSERT_NOW(a_flip_sum, aclk, aresetn, out_beat && m_flipped, step_flip, "flip without sum change of two")
    // a never loaded site is never flipped
    `ISMU_ASSERT_NOW(a_nl_flip, aclk, aresetn, m_valid && m_not_loaded, !m_flipped, "flip on unloaded site")
    // one item at a time: ready drops after an accepted beat
    `ISMU_ASSERT_NEXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready, "second beat taken back to back")
    // a stalled result stays put
    `ISMU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_magnet_sum), "stalled result changed")

endmodule

bind ising_metropolis_site_update_unit ismu_checker u_ismu_checker (.*);

`default_nettype wire
